>>> design/prime_factorization_trial_assert.svh
// assertion macros for the prime factorization block
`ifndef PRIME_FACTORIZATION_TRIAL_ASSERT_SVH
`define PRIME_FACTORIZATION_TRIAL_ASSERT_SVH

// same-cycle implication under reset
`define PFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pft_pkg.sv
// shared widths and control structs for the prime factorization block
package pft_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [DIV_WIDTH-1:0]   divisor;
    } pft_div_req_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIV_WIDTH-1:0]   remainder;
    } pft_div_rsp_t;

endpackage

>>> design/prime_factorization_trial.sv
// prime factorization by trial division: sequencer around a shared divider
// each trial divisor is issued, divided one quotient bit per step, then decided
// a value needs about max(second-largest prime, sqrt of largest) + multiplicity
// trial divisions; worst case a prime near 2**32 needs about 65535 divisors
// one item at a time: busy is high from acceptance until the last factor, if any
// rst_n clears the sequencer to idle; results are never held off by the receiver
module prime_factorization_trial
    import pft_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   busy,
    output logic                   factor_valid,
    output logic [VALUE_WIDTH-1:0] factor,
    output logic                   last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] remaining_reg;
    logic [DIV_WIDTH-1:0]   trial_divisor_reg;
    logic                   factor_valid_reg;
    logic [VALUE_WIDTH-1:0] factor_reg;
    logic                   last_reg;

    pft_div_req_t div_req;
    pft_div_rsp_t div_rsp;
    logic         past_root;
    logic         exact;

    assign div_req.start    = (state_reg == S_ISSUE);
    assign div_req.dividend = remaining_reg;
    assign div_req.divisor  = trial_divisor_reg;

    pft_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // divisor above quotient means divisor squared exceeds remaining
    assign past_root = (VALUE_WIDTH'(trial_divisor_reg) > div_rsp.quotient);
    assign exact     = (div_rsp.remainder == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            remaining_reg     <= '0;
            trial_divisor_reg <= DIV_WIDTH'(2);
            factor_valid_reg  <= 1'b0;
            factor_reg        <= '0;
            last_reg          <= 1'b0;
        end
        else
        begin
            factor_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        remaining_reg     <= value;
                        trial_divisor_reg <= DIV_WIDTH'(2);
                        state_reg         <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        priority if (past_root)
                        begin
                            if (remaining_reg > VALUE_WIDTH'(1))
                            begin
                                factor_valid_reg <= 1'b1;
                                factor_reg       <= remaining_reg;
                                last_reg         <= 1'b1;
                            end
                            state_reg <= S_IDLE;
                        end
                        else if (exact)
                        begin
                            factor_valid_reg <= 1'b1;
                            factor_reg       <= VALUE_WIDTH'(trial_divisor_reg);
                            last_reg         <= 1'b0;
                            remaining_reg    <= div_rsp.quotient;
                            state_reg        <= S_ISSUE;
                        end
                        else
                        begin
                            trial_divisor_reg <= trial_divisor_reg + DIV_WIDTH'(1);
                            state_reg         <= S_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign factor_valid = factor_valid_reg;
    assign factor       = factor_reg;
    assign last         = last_reg;

endmodule

>>> design/pft_divider.sv
// iterative restoring divider, one quotient bit per cycle
module pft_divider
    import pft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  pft_div_req_t req,
    output pft_div_rsp_t rsp
);

    logic                   active_reg;
    logic                   done_reg;
    logic [CNT_WIDTH-1:0]   count_reg;
    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [DIV_WIDTH-1:0]   rem_reg;
    logic [DIV_WIDTH-1:0]   divisor_reg;

    logic [DIV_WIDTH:0]     shifted;
    logic [DIV_WIDTH:0]     diff;
    logic                   fits;
    logic [DIV_WIDTH-1:0]   rem_next;
    logic [VALUE_WIDTH-1:0] quot_next;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[VALUE_WIDTH-1]};
        diff      = shifted - {1'b0, divisor_reg};
        fits      = (shifted >= {1'b0, divisor_reg});
        rem_next  = fits ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
        quot_next = {quot_reg[VALUE_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                count_reg  <= CNT_WIDTH'(VALUE_WIDTH);
            end
            else if (active_reg)
            begin
                count_reg <= count_reg - CNT_WIDTH'(1);
                if (count_reg == CNT_WIDTH'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (active_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> design/pft_checker.sv
// port-level checker for the prime factorization block, with its bind
`include "prime_factorization_trial_assert.svh"

module pft_checker
    import pft_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   factor_valid,
    input logic [VALUE_WIDTH-1:0] factor,
    input logic                   last
);

    `PFT_ASSERT_SAME(a_factor_min, clk, rst_n, factor_valid,
        factor >= VALUE_WIDTH'(2), "factor below two")
    `PFT_ASSERT_SAME(a_last_ends_item, clk, rst_n, factor_valid && last,
        !busy, "busy after last factor")
    `PFT_ASSERT_SAME(a_mid_factor_busy, clk, rst_n, factor_valid && !last,
        busy, "idle with factors pending")
    `PFT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy,
        busy && !factor_valid, "item not taken")

endmodule

bind prime_factorization_trial pft_checker u_pft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .factor_valid (factor_valid),
    .factor       (factor),
    .last         (last)
);
